// ===== rtl/hcd_pkg.sv =====
// Shared types, codes and arithmetic helpers for the Hill cipher decryption block.
package hcd_pkg;

    localparam int MOD_SYM       = 61;
    localparam int MAX_KEY_ORDER = 16;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PREP  = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [1:0] STS_PLAIN    = 2'd0;
    localparam logic [1:0] STS_READY    = 2'd1;
    localparam logic [1:0] STS_SINGULAR = 2'd2;
    localparam logic [1:0] STS_NO_KEY   = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] row;
        logic [3:0] col;
        logic [5:0] val;
        logic [5:0] sym;
    } hcd_req_t;

    typedef logic [5:0] inv_tab_t [64];

    function automatic inv_tab_t build_inv_table();
        inv_tab_t t;
        for (int a = 0; a < 64; a++) begin
            t[a] = '0;
            for (int b = 1; b < MOD_SYM; b++) begin
                if (((a % MOD_SYM) * b) % MOD_SYM == 1) begin
                    t[a] = 6'(b);
                end
            end
        end
        return t;
    endfunction

    localparam inv_tab_t INV_TABLE = build_inv_table();

    // Reduction uses 64 = 3 (mod 61) twice, then one conditional subtract.
    function automatic logic [5:0] mod61(input logic [12:0] x);
        logic [8:0] y;
        logic [6:0] z;
        y = 9'(x[12:6]) * 9'd3 + 9'(x[5:0]);
        z = 7'(y[8:6]) * 7'd3 + 7'(y[5:0]);
        return (z >= 7'd61) ? 6'(z - 7'd61) : 6'(z);
    endfunction

    function automatic logic [5:0] byte_to_sym(input logic [7:0] b);
        logic [5:0] s;
        case (b) inside
            [8'h41:8'h5A]: s = 6'(b - 8'd64);
            [8'h61:8'h7A]: s = 6'(b - 8'd70);
            8'h20:         s = 6'd53;
            8'h2E:         s = 6'd54;
            8'h2C:         s = 6'd55;
            8'h3A:         s = 6'd56;
            8'h21:         s = 6'd57;
            8'h3F:         s = 6'd58;
            8'h22:         s = 6'd59;
            8'h0A:         s = 6'd60;
            default:       s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] sym_to_byte(input logic [5:0] s);
        logic [7:0] b;
        case (s) inside
            [6'd1:6'd26]:  b = 8'(s) + 8'd64;
            [6'd27:6'd52]: b = 8'(s) + 8'd70;
            6'd53:         b = 8'h20;
            6'd54:         b = 8'h2E;
            6'd55:         b = 8'h2C;
            6'd56:         b = 8'h3A;
            6'd57:         b = 8'h21;
            6'd58:         b = 8'h3F;
            6'd59:         b = 8'h22;
            6'd60:         b = 8'h0A;
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/hcd_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module hcd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // key_row, key_col, key_value, in_byte
    input  logic [1:0]       s_tuser,   // command
    output logic             req_valid,
    output hcd_pkg::hcd_req_t req,
    input  logic             req_ready
);
    import hcd_pkg::*;

    hcd_req_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    hcd_req_t   entry;
    logic       push;
    logic       pop;

    always_comb begin
        entry.cmd = s_tuser;
        entry.row = s_tdata[3:0];
        entry.col = s_tdata[7:4];
        entry.val = (s_tdata[13:8] >= 6'd61) ? 6'(s_tdata[13:8] - 6'd61) : s_tdata[13:8];
        entry.sym = byte_to_sym(s_tdata[21:14]);
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid & s_tready;
    assign pop       = req_valid & req_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end

endmodule

// ===== rtl/hcd_back.sv =====
// Back end: key store, Gauss-Jordan inversion mod 61, block multiply and result register.
module hcd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [4:0]       cfg_wdata,
    input  logic             req_valid,
    input  hcd_pkg::hcd_req_t req,
    output logic             req_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import hcd_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CP_RD = 5'd1;
    localparam logic [4:0] ST_CP_WR = 5'd2;
    localparam logic [4:0] ST_PV_RD = 5'd3;
    localparam logic [4:0] ST_PV_CK = 5'd4;
    localparam logic [4:0] ST_SW_RD = 5'd5;
    localparam logic [4:0] ST_SW_W1 = 5'd6;
    localparam logic [4:0] ST_SW_W2 = 5'd7;
    localparam logic [4:0] ST_PS_RD = 5'd8;
    localparam logic [4:0] ST_PS_LD = 5'd9;
    localparam logic [4:0] ST_SC_RD = 5'd10;
    localparam logic [4:0] ST_SC_WR = 5'd11;
    localparam logic [4:0] ST_EL_FR = 5'd12;
    localparam logic [4:0] ST_EL_FQ = 5'd13;
    localparam logic [4:0] ST_EL_RD = 5'd14;
    localparam logic [4:0] ST_EL_WR = 5'd15;
    localparam logic [4:0] ST_EM_RD = 5'd16;
    localparam logic [4:0] ST_EM_AC = 5'd17;
    localparam logic [4:0] ST_PUSH  = 5'd18;

    logic [5:0] key_mem  [256];
    logic [5:0] work_mem [256];
    logic [5:0] inv_mem  [256];

    logic [5:0] key_q_reg, work_qa_reg, work_qb_reg, inv_qa_reg, inv_qb_reg, sym_q_reg;

    logic [4:0] state_reg, state_next, ret_reg, ret_next;
    logic [3:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [3:0] c_reg, c_next, p_reg, p_next, r_reg, r_next;
    logic [3:0] cnt_m1_reg, cnt_m1_next;
    logic [5:0] acc_reg, acc_next, s_reg, s_next, f_reg, f_next;
    logic       inv_valid_reg, inv_valid_next;
    logic [4:0] fill_reg, fill_next, key_size_reg, key_size_next;
    logic [5:0] sym_blk_reg [MAX_KEY_ORDER];
    logic [5:0] sym_blk_next [MAX_KEY_ORDER];
    logic [7:0] res_byte_reg, res_byte_next;
    logic [1:0] res_status_reg, res_status_next;
    logic       res_last_reg, res_last_next;

    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic [1:0] m_status_reg;
    logic       m_last_reg;

    logic       key_we, work_we, inv_we, load, row_done;
    logic [7:0] key_wa, work_wa, inv_wa, key_ra, work_ra, work_rb, inv_ra, inv_rb;
    logic [5:0] key_wd, work_wd, inv_wd, acc_new;
    logic [3:0] nm1;

    assign nm1 = 4'(key_size_reg - 5'd1);

    always_comb begin
        key_ra  = {i_reg, j_reg};
        work_rb = {c_reg, j_reg};
        inv_rb  = {c_reg, j_reg};
        case (state_reg)
            ST_PV_RD: work_ra = {p_reg, c_reg};
            ST_PS_RD: work_ra = {c_reg, c_reg};
            ST_SC_RD: work_ra = {c_reg, j_reg};
            ST_EL_FR: work_ra = {r_reg, c_reg};
            ST_EL_RD: work_ra = {r_reg, j_reg};
            default:  work_ra = {p_reg, j_reg};
        endcase
        case (state_reg)
            ST_SC_RD: inv_ra = {c_reg, j_reg};
            ST_EL_RD: inv_ra = {r_reg, j_reg};
            ST_EM_RD: inv_ra = {i_reg, k_reg};
            default:  inv_ra = {p_reg, j_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
        key_q_reg <= key_mem[key_ra];
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[work_wa] <= work_wd;
        end
        work_qa_reg <= work_mem[work_ra];
        work_qb_reg <= work_mem[work_rb];
    end

    always_ff @(posedge aclk) begin
        if (inv_we) begin
            inv_mem[inv_wa] <= inv_wd;
        end
        inv_qa_reg <= inv_mem[inv_ra];
        inv_qb_reg <= inv_mem[inv_rb];
    end

    always_ff @(posedge aclk) begin
        sym_q_reg <= sym_blk_reg[k_reg];
    end

    assign acc_new = mod61(13'(acc_reg) + 13'(inv_qa_reg) * 13'(sym_q_reg));

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        c_next          = c_reg;
        p_next          = p_reg;
        r_next          = r_reg;
        cnt_m1_next     = cnt_m1_reg;
        acc_next        = acc_reg;
        s_next          = s_reg;
        f_next          = f_reg;
        inv_valid_next  = inv_valid_reg;
        fill_next       = fill_reg;
        key_size_next   = key_size_reg;
        sym_blk_next    = sym_blk_reg;
        res_byte_next   = res_byte_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        req_ready       = 1'b0;
        key_we          = 1'b0;
        key_wa          = {req.row, req.col};
        key_wd          = req.val;
        work_we         = 1'b0;
        work_wa         = {p_reg, j_reg};
        work_wd         = work_qb_reg;
        inv_we          = 1'b0;
        inv_wa          = {p_reg, j_reg};
        inv_wd          = inv_qb_reg;
        load            = 1'b0;
        row_done        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    case (req.cmd)
                        CMD_LOAD: begin
                            key_we         = 1'b1;
                            inv_valid_next = 1'b0;
                        end
                        CMD_PREP: begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_CP_RD;
                        end
                        CMD_BYTE: begin
                            if (!inv_valid_reg) begin
                                res_byte_next   = '0;
                                res_status_next = STS_NO_KEY;
                                res_last_next   = 1'b1;
                                ret_next        = ST_IDLE;
                                state_next      = ST_PUSH;
                            end else begin
                                sym_blk_next[fill_reg[3:0]] = req.sym;
                                if (5'(fill_reg + 5'd1) >= key_size_reg) begin
                                    fill_next   = '0;
                                    cnt_m1_next = nm1;
                                    i_next      = '0;
                                    k_next      = '0;
                                    acc_next    = '0;
                                    state_next  = ST_EM_RD;
                                end else begin
                                    fill_next = 5'(fill_reg + 5'd1);
                                end
                            end
                        end
                        default: begin
                            if (fill_reg != '0) begin
                                fill_next = '0;
                                if (!inv_valid_reg) begin
                                    for (int e = 0; e < MAX_KEY_ORDER; e++) begin
                                        sym_blk_next[e] = '0;
                                    end
                                    res_byte_next   = '0;
                                    res_status_next = STS_NO_KEY;
                                    res_last_next   = 1'b1;
                                    ret_next        = ST_IDLE;
                                    state_next      = ST_PUSH;
                                end else begin
                                    cnt_m1_next = 4'(fill_reg - 5'd1);
                                    i_next      = '0;
                                    k_next      = '0;
                                    acc_next    = '0;
                                    state_next  = ST_EM_RD;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_CP_RD: state_next = ST_CP_WR;
            ST_CP_WR: begin
                work_we = 1'b1;
                work_wa = {i_reg, j_reg};
                work_wd = key_q_reg;
                inv_we  = 1'b1;
                inv_wa  = {i_reg, j_reg};
                inv_wd  = (i_reg == j_reg) ? 6'd1 : 6'd0;
                state_next = ST_CP_RD;
                if (j_reg == nm1) begin
                    j_next = '0;
                    if (i_reg == nm1) begin
                        c_next     = '0;
                        p_next     = '0;
                        state_next = ST_PV_RD;
                    end else begin
                        i_next = 4'(i_reg + 4'd1);
                    end
                end else begin
                    j_next = 4'(j_reg + 4'd1);
                end
            end
            ST_PV_RD: state_next = ST_PV_CK;
            ST_PV_CK: begin
                if (work_qa_reg != '0) begin
                    j_next     = '0;
                    state_next = (p_reg != c_reg) ? ST_SW_RD : ST_PS_RD;
                end else if (p_reg == nm1) begin
                    inv_valid_next  = 1'b0;
                    res_byte_next   = '0;
                    res_status_next = STS_SINGULAR;
                    res_last_next   = 1'b1;
                    ret_next        = ST_IDLE;
                    state_next      = ST_PUSH;
                end else begin
                    p_next     = 4'(p_reg + 4'd1);
                    state_next = ST_PV_RD;
                end
            end
            ST_SW_RD: state_next = ST_SW_W1;
            ST_SW_W1: begin
                work_we    = 1'b1;
                inv_we     = 1'b1;
                state_next = ST_SW_W2;
            end
            ST_SW_W2: begin
                work_we = 1'b1;
                work_wa = {c_reg, j_reg};
                work_wd = work_qa_reg;
                inv_we  = 1'b1;
                inv_wa  = {c_reg, j_reg};
                inv_wd  = inv_qa_reg;
                if (j_reg == nm1) begin
                    state_next = ST_PS_RD;
                end else begin
                    j_next     = 4'(j_reg + 4'd1);
                    state_next = ST_SW_RD;
                end
            end
            ST_PS_RD: state_next = ST_PS_LD;
            ST_PS_LD: begin
                s_next     = INV_TABLE[work_qa_reg];
                j_next     = '0;
                state_next = ST_SC_RD;
            end
            ST_SC_RD: state_next = ST_SC_WR;
            ST_SC_WR: begin
                work_we = 1'b1;
                work_wa = {c_reg, j_reg};
                work_wd = mod61(13'(work_qa_reg) * 13'(s_reg));
                inv_we  = 1'b1;
                inv_wa  = {c_reg, j_reg};
                inv_wd  = mod61(13'(inv_qa_reg) * 13'(s_reg));
                if (j_reg == nm1) begin
                    r_next     = '0;
                    state_next = ST_EL_FR;
                end else begin
                    j_next     = 4'(j_reg + 4'd1);
                    state_next = ST_SC_RD;
                end
            end
            ST_EL_FR: state_next = ST_EL_FQ;
            ST_EL_FQ: begin
                if (r_reg == c_reg || work_qa_reg == '0) begin
                    row_done = 1'b1;
                end else begin
                    f_next     = 6'd61 - work_qa_reg;
                    j_next     = '0;
                    state_next = ST_EL_RD;
                end
            end
            ST_EL_RD: state_next = ST_EL_WR;
            ST_EL_WR: begin
                work_we = 1'b1;
                work_wa = {r_reg, j_reg};
                work_wd = mod61(13'(work_qa_reg) + 13'(f_reg) * 13'(work_qb_reg));
                inv_we  = 1'b1;
                inv_wa  = {r_reg, j_reg};
                inv_wd  = mod61(13'(inv_qa_reg) + 13'(f_reg) * 13'(inv_qb_reg));
                if (j_reg == nm1) begin
                    row_done = 1'b1;
                end else begin
                    j_next     = 4'(j_reg + 4'd1);
                    state_next = ST_EL_RD;
                end
            end
            ST_EM_RD: state_next = ST_EM_AC;
            ST_EM_AC: begin
                if (k_reg == nm1) begin
                    res_byte_next   = sym_to_byte(acc_new);
                    res_status_next = STS_PLAIN;
                    res_last_next   = (i_reg == cnt_m1_reg);
                    state_next      = ST_PUSH;
                    if (i_reg == cnt_m1_reg) begin
                        ret_next = ST_IDLE;
                        for (int e = 0; e < MAX_KEY_ORDER; e++) begin
                            sym_blk_next[e] = '0;
                        end
                    end else begin
                        ret_next = ST_EM_RD;
                        i_next   = 4'(i_reg + 4'd1);
                        k_next   = '0;
                        acc_next = '0;
                    end
                end else begin
                    acc_next   = acc_new;
                    k_next     = 4'(k_reg + 4'd1);
                    state_next = ST_EM_RD;
                end
            end
            ST_PUSH: begin
                if (!m_valid_reg || m_tready) begin
                    load       = 1'b1;
                    state_next = ret_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (row_done) begin
            if (r_reg == nm1) begin
                if (c_reg == nm1) begin
                    inv_valid_next  = 1'b1;
                    res_byte_next   = '0;
                    res_status_next = STS_READY;
                    res_last_next   = 1'b1;
                    ret_next        = ST_IDLE;
                    state_next      = ST_PUSH;
                end else begin
                    c_next     = 4'(c_reg + 4'd1);
                    p_next     = 4'(c_reg + 4'd1);
                    state_next = ST_PV_RD;
                end
            end else begin
                r_next     = 4'(r_reg + 4'd1);
                state_next = ST_EL_FR;
            end
        end

        if (cfg_wen) begin
            if (cfg_wdata == '0) begin
                key_size_next = 5'd1;
            end else if (cfg_wdata > 5'(MAX_KEY_ORDER)) begin
                key_size_next = 5'(MAX_KEY_ORDER);
            end else begin
                key_size_next = cfg_wdata;
            end
            inv_valid_next = 1'b0;
            fill_next      = '0;
            for (int e = 0; e < MAX_KEY_ORDER; e++) begin
                sym_blk_next[e] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            c_reg         <= '0;
            p_reg         <= '0;
            r_reg         <= '0;
            cnt_m1_reg    <= '0;
            inv_valid_reg <= 1'b0;
            fill_reg      <= '0;
            key_size_reg  <= 5'd2;
            m_valid_reg   <= 1'b0;
            for (int e = 0; e < MAX_KEY_ORDER; e++) begin
                sym_blk_reg[e] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            c_reg         <= c_next;
            p_reg         <= p_next;
            r_reg         <= r_next;
            cnt_m1_reg    <= cnt_m1_next;
            inv_valid_reg <= inv_valid_next;
            fill_reg      <= fill_next;
            key_size_reg  <= key_size_next;
            sym_blk_reg   <= sym_blk_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg        <= acc_next;
        s_reg          <= s_next;
        f_reg          <= f_next;
        res_byte_reg   <= res_byte_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        if (load) begin
            m_byte_reg   <= res_byte_reg;
            m_status_reg <= res_status_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    a_fill_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < key_size_reg)
        else $error("Block fill reached the key size outside a block multiply.");

    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SW_W2) |-> ($past(state_reg) == ST_SW_W1))
        else $error("Second half of a row swap did not follow the first.");

    a_ready_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(inv_valid_reg) |->
            ($past(state_reg) == ST_EL_FQ || $past(state_reg) == ST_EL_WR))
        else $error("Inverse marked valid without finishing elimination.");

endmodule

// ===== rtl/hill_cipher_decrypt.sv =====
// Top level of the Hill cipher decryption block over a 61-symbol alphabet.
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   tuser command; tdata row, col, value, byte
//  m_        out        m_tvalid/m_tready   tuser status; tdata plaintext byte; tlast
//  cfg_      in         cfg_wen             key size
//
// A key load, or a byte that leaves a block incomplete under a valid inverse, is handled in idle.
// A full block of n symbols gives n bytes, each a sum of n products read and accumulated in turn.
// Preparing the key reads each matrix entry in a read state and writes it in the write states after it.
// Reset is synchronous and active low; the key, work and inverse stores are not cleared.
// A two-entry request queue lets requests be taken while results wait on m_tready.
module hill_cipher_decrypt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_row, key_col, key_value, in_byte, zero pad
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast
);
    import hcd_pkg::*;

    hcd_req_t req;
    logic     req_valid;
    logic     req_ready;

    hcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    hcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
